// ----- rtl/tao_pkg.sv -----
// Shared types, constants and the arctangent table builder for the octant atan2 unit.
// No dependencies; every rtl file imports it.
package tao_pkg;

	localparam int TABLE_STEPS = 1024;
	localparam int DATA_W      = 16;
	localparam int MAG_W       = 16;
	localparam int IDX_W       = $clog2(TABLE_STEPS + 1);
	localparam int DVD_W       = MAG_W + IDX_W;
	localparam int ROM_W       = 13;
	localparam int ROM_DEPTH   = TABLE_STEPS + 1;

	localparam logic signed [DATA_W-1:0] PI_Q13      = 16'sd25736;
	localparam logic signed [DATA_W-1:0] HALF_PI_Q13 = 16'sd12868;

	typedef logic [MAG_W-1:0] mag_t;
	typedef logic [DVD_W-1:0] dvd_t;
	typedef logic [IDX_W-1:0] idx_t;
	typedef logic [ROM_W-1:0] rom_word_t;
	typedef rom_word_t rom_array_t [ROM_DEPTH];

	// Octant of one sample: signs, which magnitude is larger, and the origin case.
	typedef struct packed {
		logic y_neg;
		logic x_neg;
		logic swap;
		logic zero;
	} oct_t;

	// Unsigned 64-bit quotient by shift and subtract; evaluated only while building the table.
	function automatic logic [63:0] udiv64(input logic [63:0] dividend,
			input logic [63:0] divisor);
		logic [63:0] quo;
		logic [64:0] rem;
		int          b;
		quo = '0;
		rem = '0;
		for (b = 63; b >= 0; b--) begin
			rem = {rem[63:0], dividend[b]};
			if (rem >= {1'b0, divisor}) begin
				rem    = rem - {1'b0, divisor};
				quo[b] = 1'b1;
			end
		end
		return quo;
	endfunction

	// atan(idx / TABLE_STEPS) in Q0.13, from the Euler series in Q1.31 with truncation.
	function automatic rom_word_t atan_entry(input int unsigned idx);
		logic [63:0] one;
		logic [63:0] t;
		logic [63:0] t2;
		logic [63:0] den;
		logic [63:0] ysq;
		logic [63:0] coef;
		logic [63:0] term;
		logic [63:0] sum;
		logic [63:0] v;
		int          n;
		one  = 64'd1 << 31;
		t    = udiv64(64'(idx) << 31, 64'(TABLE_STEPS));
		t2   = (t * t) >> 31;
		den  = one + t2;
		ysq  = udiv64(t2 << 31, den);
		coef = udiv64(t << 31, den);
		term = one;
		sum  = one;
		for (n = 1; n < 64; n++) begin
			if (term != 64'd0) begin
				term = (term * ysq) >> 31;
				term = udiv64(term * 64'(2 * n), 64'(2 * n + 1));
				sum  = sum + term;
			end
		end
		v = (coef * sum) >> 31;
		return ROM_W'((v + (64'd1 << 17)) >> 18);
	endfunction

	function automatic rom_array_t build_rom();
		rom_array_t r;
		int         i;
		for (i = 0; i < ROM_DEPTH; i++) begin
			r[i] = atan_entry(i);
		end
		return r;
	endfunction

endpackage

// ----- rtl/table_atan2_octant_unit.sv -----
// Four-quadrant atan2 by octant reduction, pipelined index divider and table lookup.
// Depends on tao_pkg, tao_div_step and tao_rom.
//
//   channel  valid      stall       payload
//   input    in_valid   in_stall    y_value, x_value (signed 16)
//   output   out_valid  out_stall   angle (signed Q3.13), both_zero
//
// One transaction enters per cycle while in_stall is low; it passes stage 1, stage 2,
// the divider steps, which resolve one index bit per stage, the table read and the output register.
// Each stage advances when it is empty or the stage after it advances, so bubbles
// collapse and input is taken while a finished result waits at the output, as long as some stage is empty.
// Reset clears only the valid bits; payload registers hold whatever they had.
module table_atan2_octant_unit import tao_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_stall,
	input  logic signed [DATA_W-1:0] y_value,
	input  logic signed [DATA_W-1:0] x_value,
	output logic                     out_valid,
	input  logic                     out_stall,
	output logic signed [DATA_W-1:0] angle,
	output logic                     both_zero
);

	// stage 1: magnitudes, octant, small/large operands
	logic valid_s1;
	mag_t small_s1;
	mag_t large_s1;
	oct_t oct_s1;
	logic ready_s1;

	// stage 2: dividend small * TABLE_STEPS, divisor aligned to the top index bit
	logic valid_s2;
	dvd_t dvd_s2;
	dvd_t dsh_s2;
	oct_t oct_s2;
	logic ready_s2;

	// divider chain, one entry per step boundary
	logic chain_valid [IDX_W+1];
	logic chain_ready [IDX_W+1];
	dvd_t chain_rem   [IDX_W+1];
	dvd_t chain_dsh   [IDX_W+1];
	idx_t chain_quo   [IDX_W+1];
	oct_t chain_oct   [IDX_W+1];

	// stage 3: table read
	logic      valid_s3;
	oct_t      oct_s3;
	rom_word_t rom_s3;
	logic      ready_s3;

	// stage 4: angle assembly, output register
	logic                     valid_s4;
	logic signed [DATA_W-1:0] angle_s4;
	logic                     both_zero_s4;
	logic                     ready_s4;

	mag_t                     mag_y;
	mag_t                     mag_x;
	oct_t                     oct_in;
	logic signed [DATA_W-1:0] t_ext;
	logic signed [DATA_W-1:0] angle_d;

	// ---------------------------------------------------------------- ready chain
	assign ready_s4 = !valid_s4 || !out_stall;
	assign ready_s3 = !valid_s3 || ready_s4;
	assign ready_s2 = !valid_s2 || chain_ready[0];
	assign ready_s1 = !valid_s1 || ready_s2;
	assign in_stall = !ready_s1;

	// ---------------------------------------------------------------- stage 1
	// magnitude of -32768 wraps to 0x8000, which reads as 32768 unsigned
	assign mag_y = y_value[DATA_W-1] ? mag_t'(-y_value) : mag_t'(y_value);
	assign mag_x = x_value[DATA_W-1] ? mag_t'(-x_value) : mag_t'(x_value);

	always_comb begin
		oct_in.y_neg = y_value[DATA_W-1];
		oct_in.x_neg = x_value[DATA_W-1];
		oct_in.swap  = mag_y > mag_x;
		oct_in.zero  = (y_value == '0) && (x_value == '0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (ready_s1) begin
			valid_s1 <= in_valid;
		end
	end

	// at the origin divide 0 by 1 so the index stays inside the table
	always_ff @(posedge clk) begin
		if (ready_s1) begin
			oct_s1 <= oct_in;
			if (oct_in.zero) begin
				small_s1 <= '0;
				large_s1 <= mag_t'(1);
			end else if (oct_in.swap) begin
				small_s1 <= mag_x;
				large_s1 <= mag_y;
			end else begin
				small_s1 <= mag_y;
				large_s1 <= mag_x;
			end
		end
	end

	// ---------------------------------------------------------------- stage 2
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (ready_s2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (ready_s2) begin
			dvd_s2 <= DVD_W'(small_s1) * DVD_W'(TABLE_STEPS);
			dsh_s2 <= DVD_W'(large_s1) << (IDX_W - 1);
			oct_s2 <= oct_s1;
		end
	end

	// ---------------------------------------------------------------- divider
	assign chain_valid[0]     = valid_s2;
	assign chain_rem[0]       = dvd_s2;
	assign chain_dsh[0]       = dsh_s2;
	assign chain_quo[0]       = '0;
	assign chain_oct[0]       = oct_s2;
	assign chain_ready[IDX_W] = ready_s3;

	for (genvar j = 0; j < IDX_W; j++) begin : g_div
		tao_div_step u_step (
			.clk      (clk),
			.arst_n   (arst_n),
			.up_valid (chain_valid[j]),
			.up_ready (chain_ready[j]),
			.rem_in   (chain_rem[j]),
			.dsh_in   (chain_dsh[j]),
			.quo_in   (chain_quo[j]),
			.oct_in   (chain_oct[j]),
			.dn_valid (chain_valid[j+1]),
			.dn_ready (chain_ready[j+1]),
			.rem_out  (chain_rem[j+1]),
			.dsh_out  (chain_dsh[j+1]),
			.quo_out  (chain_quo[j+1]),
			.oct_out  (chain_oct[j+1])
		);
	end

	// ---------------------------------------------------------------- stage 3
	tao_rom u_rom (
		.clk   (clk),
		.rd_en (ready_s3),
		.addr  (chain_quo[IDX_W]),
		.data  (rom_s3)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (ready_s3) begin
			valid_s3 <= chain_valid[IDX_W];
		end
	end

	always_ff @(posedge clk) begin
		if (ready_s3) begin
			oct_s3 <= chain_oct[IDX_W];
		end
	end

	// ---------------------------------------------------------------- stage 4
	// fold the table angle back into its octant around 0, +-pi/2 or +-pi
	always_comb begin
		t_ext = signed'(DATA_W'(rom_s3));
		if (oct_s3.zero) begin
			angle_d = '0;
		end else if (oct_s3.y_neg) begin
			if (oct_s3.x_neg) begin
				angle_d = oct_s3.swap ? -HALF_PI_Q13 - t_ext : t_ext - PI_Q13;
			end else begin
				angle_d = oct_s3.swap ? t_ext - HALF_PI_Q13 : -t_ext;
			end
		end else begin
			if (oct_s3.x_neg) begin
				angle_d = oct_s3.swap ? HALF_PI_Q13 + t_ext : PI_Q13 - t_ext;
			end else begin
				angle_d = oct_s3.swap ? HALF_PI_Q13 - t_ext : t_ext;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s4 <= 1'b0;
		end else if (ready_s4) begin
			valid_s4 <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (ready_s4) begin
			angle_s4     <= angle_d;
			both_zero_s4 <= oct_s3.zero;
		end
	end

	assign out_valid = valid_s4;
	assign angle     = angle_s4;
	assign both_zero = both_zero_s4;

	// ---------------------------------------------------------------- checks
	// the divider never produces an index past the last table entry
	a_index_in_table: assert property (@(posedge clk) disable iff (!arst_n)
		chain_valid[IDX_W] |-> (int'(chain_quo[IDX_W]) <= TABLE_STEPS))
		else $error("table index beyond last entry");

	// final remainder stays at or below twice the last shifted value (the divisor with its low bit cleared)
	a_remainder_bound: assert property (@(posedge clk) disable iff (!arst_n)
		chain_valid[IDX_W] |-> (chain_rem[IDX_W] <= (chain_dsh[IDX_W] << 1)))
		else $error("divider remainder not below divisor");

	// the origin always reports a zero angle
	a_origin_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && both_zero) |-> (angle == '0))
		else $error("origin flagged with nonzero angle");

endmodule

// ----- rtl/tao_div_step.sv -----
// One restoring-division step of the index divider: one quotient bit per stage.
// Depends on tao_pkg.
module tao_div_step import tao_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic up_valid,
	output logic up_ready,
	input  dvd_t rem_in,
	input  dvd_t dsh_in,
	input  idx_t quo_in,
	input  oct_t oct_in,
	output logic dn_valid,
	input  logic dn_ready,
	output dvd_t rem_out,
	output dvd_t dsh_out,
	output idx_t quo_out,
	output oct_t oct_out
);

	logic valid_s1;
	dvd_t rem_s1;
	dvd_t dsh_s1;
	idx_t quo_s1;
	oct_t oct_s1;
	logic fit;

	assign up_ready = !valid_s1 || dn_ready;
	assign fit      = rem_in >= dsh_in;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (up_ready) begin
			valid_s1 <= up_valid;
		end
	end

	// subtract the aligned divisor when it fits, shift the quotient bit in
	always_ff @(posedge clk) begin
		if (up_ready) begin
			rem_s1 <= fit ? rem_in - dsh_in : rem_in;
			dsh_s1 <= dsh_in >> 1;
			quo_s1 <= {quo_in[IDX_W-2:0], fit};
			oct_s1 <= oct_in;
		end
	end

	assign dn_valid = valid_s1;
	assign rem_out  = rem_s1;
	assign dsh_out  = dsh_s1;
	assign quo_out  = quo_s1;
	assign oct_out  = oct_s1;

endmodule

// ----- rtl/tao_rom.sv -----
// Arctangent table, atan(i / TABLE_STEPS) in Q0.13, with registered read data.
// Depends on tao_pkg for the table builder and widths.
module tao_rom import tao_pkg::*; (
	input  logic      clk,
	input  logic      rd_en,
	input  idx_t      addr,
	output rom_word_t data
);

	localparam rom_array_t ROM_INIT = build_rom();

	rom_word_t word_s1;

	always_ff @(posedge clk) begin
		if (rd_en) begin
			word_s1 <= ROM_INIT[addr];
		end
	end

	assign data = word_s1;

endmodule
